// File: hdl/hsp_pkg.sv
// Shared codes, result type and protocol-name table for the peer handshake parser.
// No dependencies; used by hsp_fsm and peer_handshake_parser_core.
package hsp_pkg;

	// Default field lengths of the handshake.
	localparam int RESERVED_BYTES_DEF = 8;
	localparam int HASH_BYTES_DEF     = 20;
	localparam int NAME_BYTES_DEF     = 19;
	localparam int PEER_ID_BYTES      = 20;
	localparam int HASH_BITS          = 160;
	localparam int NAME_ROM_DEPTH     = 64;

	// Parser phases.
	localparam logic [2:0] PH_LEN  = 3'd0;
	localparam logic [2:0] PH_NAME = 3'd1;
	localparam logic [2:0] PH_RSV  = 3'd2;
	localparam logic [2:0] PH_HASH = 3'd3;
	localparam logic [2:0] PH_PEER = 3'd4;

	// Field kinds reported with each byte.
	localparam logic [2:0] KIND_LEN  = 3'd0;
	localparam logic [2:0] KIND_NAME = 3'd1;
	localparam logic [2:0] KIND_RSV  = 3'd2;
	localparam logic [2:0] KIND_HASH = 3'd3;
	localparam logic [2:0] KIND_PEER = 3'd4;
	localparam logic [2:0] KIND_NONE = 3'd5;

	// Status codes.
	localparam logic [2:0] ST_MORE     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_ZERO_LEN = 3'd2;
	localparam logic [2:0] ST_BAD_NAME = 3'd3;
	localparam logic [2:0] ST_BAD_HASH = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HASH_HI  = 2'd0;
	localparam logic [1:0] CFG_HASH_MID = 2'd1;
	localparam logic [1:0] CFG_HASH_LO  = 2'd2;

	typedef struct packed {
		logic [2:0] field_kind;
		logic [7:0] field_index;
		logic [7:0] field_byte;
		logic [2:0] status;
	} hsp_result_t;

	// Expected protocol name, zero beyond its last character.
	function automatic logic [7:0] name_rom(input logic [5:0] idx);
		logic [7:0] c;
		unique case (idx)
			6'd0:    c = 8'h42; // B
			6'd1:    c = 8'h69; // i
			6'd2:    c = 8'h74; // t
			6'd3:    c = 8'h54; // T
			6'd4:    c = 8'h6f; // o
			6'd5:    c = 8'h72; // r
			6'd6:    c = 8'h72; // r
			6'd7:    c = 8'h65; // e
			6'd8:    c = 8'h6e; // n
			6'd9:    c = 8'h74; // t
			6'd10:   c = 8'h20; // space
			6'd11:   c = 8'h70; // p
			6'd12:   c = 8'h72; // r
			6'd13:   c = 8'h6f; // o
			6'd14:   c = 8'h74; // t
			6'd15:   c = 8'h6f; // o
			6'd16:   c = 8'h63; // c
			6'd17:   c = 8'h6f; // o
			6'd18:   c = 8'h6c; // l
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/hsp_fsm.sv
// Parser state machine of the peer handshake parser: phase, byte counter and
// mismatch flags, plus the result of the current byte. Depends on hsp_pkg.
module hsp_fsm
	import hsp_pkg::*;
#(
	parameter int RESERVED_BYTES = RESERVED_BYTES_DEF,
	parameter int HASH_BYTES     = HASH_BYTES_DEF,
	parameter int NAME_BYTES     = NAME_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           rx_byte,
	input  logic                 restart,
	input  logic [HASH_BITS-1:0] exp_hash,
	output hsp_result_t          result
);

	localparam logic [7:0] RSV_END  = 8'(RESERVED_BYTES);
	localparam logic [7:0] HASH_END = 8'(HASH_BYTES);
	localparam logic [7:0] NAME_END = 8'(NAME_BYTES);
	localparam logic [7:0] PEER_END = 8'(PEER_ID_BYTES);
	localparam logic [7:0] ROM_END  = 8'(NAME_ROM_DEPTH);

	logic [2:0] phase_q, phase_d;
	logic [7:0] count_q, count_d;
	logic [7:0] name_len_q, name_len_d;
	logic       name_bad_q, name_bad_d;
	logic       hash_bad_q, hash_bad_d;
	logic [2:0] final_q, final_d;

	logic [7:0] count_inc;
	logic [7:0] exp_byte;
	logic [7:0] rom_byte;

	assign count_inc = count_q + 8'd1;
	assign rom_byte  = name_rom(count_q[5:0]);
	// Hash byte 0 sits in the top bits; in the hash phase the count stays below 20.
	assign exp_byte  = exp_hash[HASH_BITS-1 - 8*count_q[4:0] -: 8];

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		name_len_d = name_len_q;
		name_bad_d = name_bad_q;
		hash_bad_d = hash_bad_q;
		final_d    = final_q;
		result.field_kind  = KIND_NONE;
		result.field_index = 8'd0;
		result.field_byte  = 8'd0;
		if (restart) begin
			phase_d    = PH_LEN;
			count_d    = 8'd0;
			name_len_d = 8'd0;
			name_bad_d = 1'b0;
			hash_bad_d = 1'b0;
			final_d    = ST_MORE;
		end else if (final_q == ST_MORE) begin
			result.field_byte  = rx_byte;
			result.field_index = count_q;
			count_d = count_inc;
			unique case (phase_q)
				PH_NAME: begin
					result.field_kind = KIND_NAME;
					if (count_q < NAME_END && count_q < ROM_END && rx_byte != rom_byte)
						name_bad_d = 1'b1;
					if (count_inc == name_len_q) begin
						if (name_bad_d) begin
							final_d = ST_BAD_NAME;
						end else begin
							phase_d = PH_RSV;
							count_d = 8'd0;
						end
					end
				end
				PH_RSV: begin
					result.field_kind = KIND_RSV;
					if (count_inc >= RSV_END) begin
						phase_d    = PH_HASH;
						count_d    = 8'd0;
						hash_bad_d = 1'b0;
					end
				end
				PH_HASH: begin
					result.field_kind = KIND_HASH;
					if (rx_byte != exp_byte)
						hash_bad_d = 1'b1;
					if (count_inc >= HASH_END) begin
						if (hash_bad_d) begin
							final_d = ST_BAD_HASH;
						end else begin
							phase_d = PH_PEER;
							count_d = 8'd0;
						end
					end
				end
				PH_PEER: begin
					result.field_kind = KIND_PEER;
					if (count_inc >= PEER_END)
						final_d = ST_DONE;
				end
				default: begin
					// Length byte; unused phase codes behave the same way.
					result.field_kind  = KIND_LEN;
					result.field_index = 8'd0;
					count_d    = count_q;
					name_len_d = rx_byte;
					if (rx_byte == 8'd0) begin
						final_d = ST_ZERO_LEN;
					end else begin
						phase_d    = PH_NAME;
						count_d    = 8'd0;
						name_bad_d = 1'b0;
					end
				end
			endcase
		end
		result.status = final_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEN;
			count_q    <= 8'd0;
			name_len_q <= 8'd0;
			name_bad_q <= 1'b0;
			hash_bad_q <= 1'b0;
			final_q    <= ST_MORE;
		end else if (advance) begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			name_len_q <= name_len_d;
			name_bad_q <= name_bad_d;
			hash_bad_q <= hash_bad_d;
			final_q    <= final_d;
		end
	end

endmodule

// File: hdl/peer_handshake_parser_core.sv
// Top level of the peer handshake parser: stream ports, hash registers and
// the result register. Depends on hsp_pkg and hsp_fsm.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata rx_byte, tuser restart
//  m_*       out  m_tvalid/m_tready  tdata index/byte/status, tuser field_kind
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// Each request yields one result in the cycle after it is accepted; one byte per
// cycle is sustained while m_tready is high, set by the single result register.
// A new request is taken while the held result is being read out; only a
// stalled, full result register holds s_tready low.
// Reset clears the parser state, the hash registers and the result valid.
module peer_handshake_parser_core
	import hsp_pkg::*;
#(
	parameter int RESERVED_BYTES = RESERVED_BYTES_DEF,
	parameter int HASH_BYTES     = HASH_BYTES_DEF,
	parameter int NAME_BYTES     = NAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] field_index, [15:8] field_byte,
	                               // [18:16] status, [23:19] zero
	output logic [2:0]  m_tuser,   // [2:0] field_kind
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] hash_hi_q;
	logic [63:0] hash_mid_q;
	logic [31:0] hash_lo_q;
	logic        out_valid_q;
	hsp_result_t out_q;
	hsp_result_t step_res;
	logic        accept;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_hi_q  <= 64'd0;
			hash_mid_q <= 64'd0;
			hash_lo_q  <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HASH_HI:  hash_hi_q  <= cfg_data;
				CFG_HASH_MID: hash_mid_q <= cfg_data;
				CFG_HASH_LO:  hash_lo_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	hsp_fsm #(
		.RESERVED_BYTES(RESERVED_BYTES),
		.HASH_BYTES    (HASH_BYTES),
		.NAME_BYTES    (NAME_BYTES)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.rx_byte (s_tdata),
		.restart (s_tuser),
		.exp_hash({hash_hi_q, hash_mid_q, hash_lo_q}),
		.result  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_q <= step_res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.field_kind;
	assign m_tdata  = {5'd0, out_q.status, out_q.field_byte, out_q.field_index};

endmodule

// File: dv/hsp_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the peer handshake parser: tracks the hash registers and the
// parse state from the accepted requests and compares every result in order.
// Depends on hsp_pkg for the field, phase and status codes and the result layout.
module hsp_result_checker
	import hsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          mismatches,
	output int          results_due
);

	// Protocol name as the parser must see it, first character in the top byte.
	localparam logic [151:0] PROTO_NAME =
		152'h42697454_6f727265_6e742070_726f746f_636f6c;

	logic [63:0] key_hi;
	logic [63:0] key_mid;
	logic [31:0] key_lo;

	logic [2:0] phase;
	logic [7:0] pos;
	logic [7:0] name_len;
	logic       name_bad;
	logic       hash_bad;
	logic [2:0] verdict;

	hsp_result_t results_q[$];

	function automatic logic [7:0] proto_char(input logic [7:0] i);
		return PROTO_NAME[8 * (NAME_BYTES_DEF - 1 - i) +: 8];
	endfunction

	function automatic logic [7:0] key_byte(input logic [7:0] i);
		logic [7:0] b;
		if (i < 8)
			b = key_hi[8 * (7 - i) +: 8];
		else if (i < 16)
			b = key_mid[8 * (15 - i) +: 8];
		else
			b = key_lo[8 * (19 - i) +: 8];
		return b;
	endfunction

	function void clear_parse();
		phase    = PH_LEN;
		pos      = '0;
		name_len = '0;
		name_bad = 1'b0;
		hash_bad = 1'b0;
		verdict  = ST_MORE;
	endfunction

	// Advances the parse state by one request and returns the result it must produce.
	function hsp_result_t parse_byte(input logic [7:0] b, input logic restart);
		hsp_result_t r;
		r.field_kind  = KIND_NONE;
		r.field_index = '0;
		r.field_byte  = '0;
		r.status      = ST_MORE;
		if (restart) begin
			clear_parse();
			return r;
		end
		if (verdict == ST_MORE) begin
			r.field_byte  = b;
			r.field_index = pos;
			case (phase)
				PH_NAME: begin
					r.field_kind = KIND_NAME;
					// Bytes past the end of the known name are consumed unchecked.
					if (pos < NAME_BYTES_DEF && b != proto_char(pos))
						name_bad = 1'b1;
					pos = pos + 8'd1;
					if (pos == name_len) begin
						if (name_bad) begin
							verdict = ST_BAD_NAME;
						end else begin
							phase = PH_RSV;
							pos   = '0;
						end
					end
				end
				PH_RSV: begin
					r.field_kind = KIND_RSV;
					pos = pos + 8'd1;
					if (pos >= RESERVED_BYTES_DEF) begin
						phase    = PH_HASH;
						pos      = '0;
						hash_bad = 1'b0;
					end
				end
				PH_HASH: begin
					r.field_kind = KIND_HASH;
					if (b != key_byte(pos))
						hash_bad = 1'b1;
					pos = pos + 8'd1;
					if (pos >= HASH_BYTES_DEF) begin
						if (hash_bad) begin
							verdict = ST_BAD_HASH;
						end else begin
							phase = PH_PEER;
							pos   = '0;
						end
					end
				end
				PH_PEER: begin
					r.field_kind = KIND_PEER;
					pos = pos + 8'd1;
					if (pos >= PEER_ID_BYTES)
						verdict = ST_DONE;
				end
				default: begin
					r.field_kind  = KIND_LEN;
					r.field_index = '0;
					name_len      = b;
					if (b == 8'd0) begin
						verdict = ST_ZERO_LEN;
					end else begin
						phase    = PH_NAME;
						pos      = '0;
						name_bad = 1'b0;
					end
				end
			endcase
		end
		r.status = verdict;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hsp_result_t want;
		hsp_result_t got;
		if (!arst_n) begin
			key_hi  = '0;
			key_mid = '0;
			key_lo  = '0;
			clear_parse();
			results_q.delete();
			results_due = 0;
			mismatches  = 0;
		end else begin
			// The result leaving now always belongs to an earlier request.
			if (m_tvalid && m_tready) begin
				got.field_kind  = m_tuser;
				got.field_index = m_tdata[7:0];
				got.field_byte  = m_tdata[15:8];
				got.status      = m_tdata[18:16];
				if (results_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request outstanding: kind %0d index %0d byte %h status %0d",
							$realtime, got.field_kind, got.field_index, got.field_byte, got.status);
				end else begin
					want = results_q.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result mismatch: expected kind %0d index %0d byte %h status %0d, got kind %0d index %0d byte %h status %0d",
								$realtime, want.field_kind, want.field_index, want.field_byte,
								want.status, got.field_kind, got.field_index, got.field_byte,
								got.status);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_HASH_HI:  key_hi  = cfg_data;
					CFG_HASH_MID: key_mid = cfg_data;
					CFG_HASH_LO:  key_lo  = cfg_data[31:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				results_q.push_back(parse_byte(s_tdata, s_tuser));
			results_due = results_q.size();
		end
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for peer_handshake_parser_core: clock, reset, request and result
// traffic, hash register writes and the verdict. Depends on hsp_pkg and hsp_result_checker.
module tb_top;
	import hsp_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 180;
	localparam int HOLD_CYCLES  = 60;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_HASH_HI;
	logic [63:0] cfg_data  = '0;

	int mismatches;
	int results_due;

	int send_idle  = 0;
	int recv_stall = 0;
	bit hold_req   = 1'b0;
	bit hold_done  = 1'b0;
	int hold_left  = 0;
	int quiet_cycles = 0;
	int sent = 0;

	// Hash currently loaded into the block, used to build matching handshakes.
	logic [63:0] key_hi  = '0;
	logic [63:0] key_mid = '0;
	logic [31:0] key_lo  = '0;

	always #1 clk = ~clk;

	peer_handshake_parser_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hsp_result_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	// Result side. A single long hold-off lets the result register fill so that
	// the parser has to back-pressure the sender.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("peer_handshake_parser_core regression: fail");
			$finish;
		end
	end

	function automatic logic [7:0] key_byte(input int i);
		logic [7:0] b;
		if (i < 8)
			b = key_hi[8 * (7 - i) +: 8];
		else if (i < 16)
			b = key_mid[8 * (15 - i) +: 8];
		else
			b = key_lo[8 * (19 - i) +: 8];
		return b;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic restart);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= restart;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Stops offering requests and waits until every result has been read out.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (results_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_key(input logic [63:0] hi, input logic [63:0] mid,
			input logic [31:0] lo);
		key_hi  = hi;
		key_mid = mid;
		key_lo  = lo;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_HASH_HI;
		cfg_data  <= hi;
		@(negedge clk);
		cfg_index <= CFG_HASH_MID;
		cfg_data  <= mid;
		@(negedge clk);
		cfg_index <= CFG_HASH_LO;
		cfg_data  <= {32'h0, lo};
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// One connection: mostly complete handshakes with random content, some with a
	// broken name or hash, odd name lengths, cut short, or plain noise; always
	// closed by a restart. A non-negative force_len fixes the name length.
	task automatic send_handshake(input int force_len);
		logic [7:0] bytes[$];
		int roll;
		int len;
		int p;
		int cut;
		bit bad_name;
		bit bad_hash;
		roll     = $urandom_range(99);
		bad_name = 1'b0;
		bad_hash = 1'b0;
		if (force_len < 0 && roll >= 88) begin
			repeat ($urandom_range(1, 30))
				push_byte(8'($urandom), $urandom_range(19) == 0);
			push_byte(8'($urandom), 1'b1);
			return;
		end
		if (force_len >= 0)
			len = force_len;
		else if (roll < 60)
			len = NAME_BYTES_DEF;
		else if (roll < 70)
			len = NAME_BYTES_DEF;
		else if (roll < 78)
			len = $urandom_range(1, NAME_BYTES_DEF - 1);
		else if (roll < 84)
			len = $urandom_range(NAME_BYTES_DEF + 1, 40);
		else
			len = 0;
		bad_hash = force_len < 0 && roll >= 50 && roll < 60;
		bad_name = force_len < 0 && roll >= 60 && roll < 70;

		bytes.push_back(len[7:0]);
		if (len != 0) begin
			for (int i = 0; i < len; i++)
				bytes.push_back(i < NAME_BYTES_DEF ? name_rom(i[5:0]) : 8'($urandom));
			for (int i = 0; i < RESERVED_BYTES_DEF; i++)
				bytes.push_back(8'($urandom));
			for (int i = 0; i < HASH_BYTES_DEF; i++)
				bytes.push_back(key_byte(i));
			for (int i = 0; i < PEER_ID_BYTES; i++)
				bytes.push_back(8'($urandom));
			if (bad_name) begin
				p = 1 + $urandom_range(((len < NAME_BYTES_DEF) ? len : NAME_BYTES_DEF) - 1);
				bytes[p] = bytes[p] ^ (8'h01 << $urandom_range(7));
			end
			if (bad_hash) begin
				p = 1 + len + RESERVED_BYTES_DEF + $urandom_range(HASH_BYTES_DEF - 1);
				bytes[p] = bytes[p] ^ (8'h01 << $urandom_range(7));
			end
			// Now and then the connection is dropped part way through.
			if ($urandom_range(9) == 0) begin
				cut = $urandom_range(1, bytes.size());
				while (bytes.size() > cut)
					void'(bytes.pop_back());
			end
		end
		// Bytes after a final status are consumed and ignored.
		repeat ($urandom_range(3))
			bytes.push_back(8'($urandom));
		foreach (bytes[i])
			push_byte(bytes[i], 1'b0);
		push_byte(8'($urandom), 1'b1);
	endtask

	initial begin
		int target;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		load_key(64'h0, 64'h0, 32'h0);

		// Restart with a set byte, zero length, then a byte after the sticky error.
		push_byte(8'hff, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b1);
		// Two-byte name whose second byte is wrong, then an ignored byte.
		push_byte(8'd2, 1'b0);
		push_byte(name_rom(6'd0), 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h5a, 1'b0);
		push_byte(8'h00, 1'b1);
		// One-byte name, reserved bytes at the extremes, a wrong first hash byte.
		push_byte(8'd1, 1'b0);
		push_byte(name_rom(6'd0), 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h7f, 1'b0);
		push_byte(8'hfe, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'haa, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					send_idle  = 0;
					recv_stall = 0;
					load_key('1, '1, '1);
				end
				1: begin
					send_idle  = 63;
					recv_stall = 0;
					load_key({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
				end
				2: begin
					send_idle  = 0;
					recv_stall = 63;
					load_key({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
				end
				default: begin
					send_idle  = 32;
					recv_stall = 32;
					load_key({32'h00ff00ff, $urandom}, {$urandom, $urandom}, 32'h0);
				end
			endcase
			target = sent + PHASE_ITEMS;
			if (ph == 0) begin
				hold_req <= 1'b1;
				send_handshake(255);
			end
			while (sent < target)
				send_handshake(-1);
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (results_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("peer_handshake_parser_core regression: pass");
		else
			$display("peer_handshake_parser_core regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
hdl/hsp_pkg.sv
hdl/hsp_fsm.sv
hdl/peer_handshake_parser_core.sv
dv/hsp_result_checker.sv
dv/tb_top.sv
